// ===== src/dar_pkg.sv =====
`default_nettype none

package dar_pkg;

	// Default repeat timing, in frames
	localparam int REPEAT_DELAY_DEF  = 30;
	localparam int SPEEDUP_AT_DEF    = 90;
	localparam int SLOW_INTERVAL_DEF = 10;
	localparam int FAST_INTERVAL_DEF = 5;

	// Field widths
	localparam int POS_W       = 16;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	// Input beat layout
	localparam int IN_X_LSB   = 0;
	localparam int IN_Y_LSB   = 16;
	localparam int IN_HAT_LSB = 32;
	localparam int IN_KEY_LSB = 48;
	localparam int IN_OK_BIT  = 52;

	// Direction lanes, also the bit order of the result beat
	localparam int DIR_UP    = 0;
	localparam int DIR_DOWN  = 1;
	localparam int DIR_LEFT  = 2;
	localparam int DIR_RIGHT = 3;
	localparam int NUM_DIR   = 4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PAD_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HAT_UP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HAT_RIGHT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HAT_DOWN   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_HAT_LEFT   = 3'd6;

	// Register reset values
	localparam logic [POS_W-1:0] LOW_THR_RST   = 16'h6fff;
	localparam logic [POS_W-1:0] HIGH_THR_RST  = 16'h8fff;
	localparam logic [POS_W-1:0] HAT_UP_RST    = 16'd0;
	localparam logic [POS_W-1:0] HAT_RIGHT_RST = 16'd9000;
	localparam logic [POS_W-1:0] HAT_DOWN_RST  = 16'd18000;
	localparam logic [POS_W-1:0] HAT_LEFT_RST  = 16'd27000;

endpackage

`default_nettype wire

// ===== src/direction_auto_repeat.sv =====
// Cursor direction pulses with typematic auto-repeat and acceleration.
//
// Input stream (s_axis_*): one beat per frame carrying stick X/Y, the hat
// code, four keyboard press edges and the pad read-ok flag. Output stream
// (m_axis_*): one beat per input beat with up/down/left/right pulse bits.
// Config channel (cfg_*): register index plus data, always ready; write only
// while no beat is in flight.
//
// A beat accepted on s_axis shows on m_axis in the next cycle. Throughput
// is one beat per cycle while the receiver takes beats; all per-frame work
// (threshold compares, hat match, hold counters, repeat table lookup) sits
// between the input handshake and the single output register.
// When the receiver stalls, the output register holds its beat and
// s_axis_tready drops until that beat is taken; a beat can be taken in the
// same cycle a new one is accepted.
// Reset: registers go to their default values, hold counters, previous pad
// readings and the keyboard-only latch clear, and the output is empty.
// A failed read in pad mode latches keyboard-only mode until the next reset.
`default_nettype none

module direction_auto_repeat #(
	parameter int REPEAT_DELAY  = dar_pkg::REPEAT_DELAY_DEF,
	parameter int SPEEDUP_AT    = dar_pkg::SPEEDUP_AT_DEF,
	parameter int SLOW_INTERVAL = dar_pkg::SLOW_INTERVAL_DEF,
	parameter int FAST_INTERVAL = dar_pkg::FAST_INTERVAL_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// stick_x, stick_y, hat_code, key_up_edge, key_down_edge,
	// key_left_edge, key_right_edge, pad_read_ok, zero pad
	input  wire logic [dar_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// move_up, move_down, move_left, move_right, zero pad
	output logic      [dar_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [dar_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [dar_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int HOLD_BASE = (SPEEDUP_AT > REPEAT_DELAY) ? SPEEDUP_AT : REPEAT_DELAY + 1;
	localparam int CAP       = HOLD_BASE + FAST_INTERVAL - 1;
	localparam int CNT_W     = $clog2(CAP + 1);
	localparam int POS_W     = dar_pkg::POS_W;
	localparam int NUM_DIR   = dar_pkg::NUM_DIR;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [POS_W-1:0] pos_t;

	// Repeat pulse per count value, built at elaboration with phase counters
	function automatic logic [CAP:0] rep_table();
		logic [CAP:0] t;
		int           slow_ph;
		int           fast_ph;
		t       = '0;
		slow_ph = 0;
		fast_ph = 0;
		for (int c = 0; c <= CAP; c++) begin
			t[c]    = (c > REPEAT_DELAY) && ((c < SPEEDUP_AT) ? (slow_ph == 0) : (fast_ph == 0));
			slow_ph = (slow_ph == SLOW_INTERVAL - 1) ? 0 : slow_ph + 1;
			fast_ph = (fast_ph == FAST_INTERVAL - 1) ? 0 : fast_ph + 1;
		end
		return t;
	endfunction

	localparam logic [CAP:0] REP_TABLE = rep_table();
	localparam cnt_t         CNT_CAP   = cnt_t'(CAP);
	localparam cnt_t         CNT_WRAP  = cnt_t'(CAP + 1 - FAST_INTERVAL);

	// Next hold count: clear on release, fall back one fast interval at the cap
	function automatic cnt_t cnt_next(input cnt_t c, input logic held);
		cnt_t n;
		if (!held) begin
			n = '0;
		end else if (c == CNT_CAP) begin
			n = CNT_WRAP;
		end else begin
			n = c + cnt_t'(1);
		end
		return n;
	endfunction

	// Configuration registers
	logic pad_mode_q;
	pos_t low_thr_q;
	pos_t high_thr_q;
	pos_t hat_cfg_q [NUM_DIR];

	// Frame state
	pos_t prev_x_q;
	pos_t prev_y_q;
	pos_t prev_hat_q;
	cnt_t stick_cnt_q [NUM_DIR];
	cnt_t hat_cnt_q [NUM_DIR];
	logic kbd_latched_q;

	// Output register
	logic                            out_valid_q;
	logic [dar_pkg::OUT_TDATA_W-1:0] out_data_q;

	// Beat fields
	pos_t               in_x;
	pos_t               in_y;
	pos_t               in_hat;
	logic [NUM_DIR-1:0] in_key;
	logic               in_ok;
	logic               s_fire;
	logic               kbd_mode;

	// Per-lane decode
	logic [NUM_DIR-1:0] stick_now;
	logic [NUM_DIR-1:0] stick_before;
	logic [NUM_DIR-1:0] hat_now;
	logic [NUM_DIR-1:0] hat_edge;
	logic [NUM_DIR-1:0] pulse;
	cnt_t               stick_cnt_d [NUM_DIR];
	cnt_t               hat_cnt_d [NUM_DIR];

	assign in_x   = s_axis_tdata[dar_pkg::IN_X_LSB +: POS_W];
	assign in_y   = s_axis_tdata[dar_pkg::IN_Y_LSB +: POS_W];
	assign in_hat = s_axis_tdata[dar_pkg::IN_HAT_LSB +: POS_W];
	assign in_key = s_axis_tdata[dar_pkg::IN_KEY_LSB +: NUM_DIR];
	assign in_ok  = s_axis_tdata[dar_pkg::IN_OK_BIT];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// A failed read already counts as keyboard mode in its own frame
	assign kbd_mode = !pad_mode_q || kbd_latched_q || !in_ok;

	// Stick threshold compares against the current and previous reading
	always_comb begin
		stick_now[dar_pkg::DIR_UP]       = in_y < low_thr_q;
		stick_now[dar_pkg::DIR_DOWN]     = in_y > high_thr_q;
		stick_now[dar_pkg::DIR_LEFT]     = in_x < low_thr_q;
		stick_now[dar_pkg::DIR_RIGHT]    = in_x > high_thr_q;
		stick_before[dar_pkg::DIR_UP]    = prev_y_q < low_thr_q;
		stick_before[dar_pkg::DIR_DOWN]  = prev_y_q > high_thr_q;
		stick_before[dar_pkg::DIR_LEFT]  = prev_x_q < low_thr_q;
		stick_before[dar_pkg::DIR_RIGHT] = prev_x_q > high_thr_q;
	end

	// Lanes: hat match, counters, pulse merge
	always_comb begin
		for (int d = 0; d < NUM_DIR; d++) begin
			hat_now[d]     = in_hat == hat_cfg_q[d];
			hat_edge[d]    = hat_now[d] && (prev_hat_q != hat_cfg_q[d]);
			stick_cnt_d[d] = cnt_next(stick_cnt_q[d], stick_now[d]);
			hat_cnt_d[d]   = cnt_next(hat_cnt_q[d], hat_now[d]);
			if (kbd_mode) begin
				pulse[d] = in_key[d];
			end else begin
				pulse[d] = in_key[d] || hat_edge[d]
					|| (stick_now[d] && !stick_before[d])
					|| (stick_now[d] && REP_TABLE[stick_cnt_d[d]])
					|| (hat_now[d] && REP_TABLE[hat_cnt_d[d]]);
			end
		end
	end

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_mode_q                     <= 1'b1;
			low_thr_q                      <= dar_pkg::LOW_THR_RST;
			high_thr_q                     <= dar_pkg::HIGH_THR_RST;
			hat_cfg_q[dar_pkg::DIR_UP]     <= dar_pkg::HAT_UP_RST;
			hat_cfg_q[dar_pkg::DIR_DOWN]   <= dar_pkg::HAT_DOWN_RST;
			hat_cfg_q[dar_pkg::DIR_LEFT]   <= dar_pkg::HAT_LEFT_RST;
			hat_cfg_q[dar_pkg::DIR_RIGHT]  <= dar_pkg::HAT_RIGHT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dar_pkg::CFG_PAD_MODE:  pad_mode_q <= cfg_data[0];
				dar_pkg::CFG_LOW_THR:   low_thr_q <= cfg_data;
				dar_pkg::CFG_HIGH_THR:  high_thr_q <= cfg_data;
				dar_pkg::CFG_HAT_UP:    hat_cfg_q[dar_pkg::DIR_UP] <= cfg_data;
				dar_pkg::CFG_HAT_RIGHT: hat_cfg_q[dar_pkg::DIR_RIGHT] <= cfg_data;
				dar_pkg::CFG_HAT_DOWN:  hat_cfg_q[dar_pkg::DIR_DOWN] <= cfg_data;
				dar_pkg::CFG_HAT_LEFT:  hat_cfg_q[dar_pkg::DIR_LEFT] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Frame state update, pad mode only; the latch sets on a failed read in pad mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q      <= '0;
			prev_y_q      <= '0;
			prev_hat_q    <= '0;
			kbd_latched_q <= 1'b0;
			for (int d = 0; d < NUM_DIR; d++) begin
				stick_cnt_q[d] <= '0;
				hat_cnt_q[d]   <= '0;
			end
		end else if (s_fire) begin
			if (pad_mode_q && !in_ok) begin
				kbd_latched_q <= 1'b1;
			end
			if (!kbd_mode) begin
				prev_x_q   <= in_x;
				prev_y_q   <= in_y;
				prev_hat_q <= in_hat;
				for (int d = 0; d < NUM_DIR; d++) begin
					stick_cnt_q[d] <= stick_cnt_d[d];
					hat_cnt_q[d]   <= hat_cnt_d[d];
				end
			end
		end
	end

	// Output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			out_data_q <= {{(dar_pkg::OUT_TDATA_W - NUM_DIR){1'b0}}, pulse};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Keyboard-only latch never clears outside reset
	a_latch_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		kbd_latched_q |=> kbd_latched_q)
		else $error("keyboard latch cleared");

	// In keyboard mode the beat is exactly the key edges
	a_kbd_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && kbd_mode) |=> (m_axis_tdata[NUM_DIR-1:0] == $past(in_key)))
		else $error("keyboard mode pulse mismatch");

	// Keyboard mode frames leave the pad history untouched
	a_kbd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && kbd_mode) |=> ($stable(prev_x_q) && $stable(prev_hat_q)
			&& $stable(stick_cnt_q[dar_pkg::DIR_UP]) && $stable(hat_cnt_q[dar_pkg::DIR_LEFT])))
		else $error("pad state moved in keyboard mode");

	// Hold counters stay within the repeat cap
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(stick_cnt_q[0] <= CNT_CAP) && (stick_cnt_q[1] <= CNT_CAP)
		&& (stick_cnt_q[2] <= CNT_CAP) && (stick_cnt_q[3] <= CNT_CAP)
		&& (hat_cnt_q[0] <= CNT_CAP) && (hat_cnt_q[1] <= CNT_CAP)
		&& (hat_cnt_q[2] <= CNT_CAP) && (hat_cnt_q[3] <= CNT_CAP))
		else $error("hold counter above cap");

endmodule

`default_nettype wire

// ===== dv/dar_move_checker.sv =====
`timescale 1ns / 100ps

module dar_move_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	// stick_x, stick_y, hat_code, key edges (up, down, left, right), pad_read_ok
	input  logic [dar_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  logic                               s_axis_tvalid,
	input  logic                               s_axis_tready,
	// move_up, move_down, move_left, move_right, zero pad
	input  logic [dar_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [dar_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dar_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                 fail_count = 0,
	output int                                 pending = 0
);
	import dar_pkg::*;

	// hold counters wrap back by one fast interval above this value
	localparam int HOLD_CAP = ((SPEEDUP_AT_DEF > REPEAT_DELAY_DEF) ? SPEEDUP_AT_DEF
		: REPEAT_DELAY_DEF + 1) + FAST_INTERVAL_DEF - 1;

	// register copy
	logic                             pad_mode;
	logic [POS_W-1:0]                 low_thr;
	logic [POS_W-1:0]                 high_thr;
	logic [NUM_DIR-1:0][POS_W-1:0]    hat_dir_code;

	// per-frame state
	logic [POS_W-1:0] prev_x;
	logic [POS_W-1:0] prev_y;
	logic [POS_W-1:0] prev_hat;
	int               stick_hold [NUM_DIR];
	int               hat_hold [NUM_DIR];
	logic             kbd_latched;

	// move bits still owed by the block, oldest first
	logic [NUM_DIR-1:0] move_q [$];
	int                 fails;

	function automatic int hold_next(input int cnt, input logic held);
		int c;
		if (!held)
			return 0;
		c = cnt + 1;
		if (c > HOLD_CAP)
			c = c - FAST_INTERVAL_DEF;
		return c;
	endfunction

	function automatic logic repeat_due(input int cnt);
		int iv;
		if (cnt <= REPEAT_DELAY_DEF)
			return 1'b0;
		iv = (cnt < SPEEDUP_AT_DEF) ? SLOW_INTERVAL_DEF : FAST_INTERVAL_DEF;
		return (cnt % iv) == 0;
	endfunction

	// Work out the move pulses of one frame and advance the state
	task automatic predict_moves(input logic [IN_TDATA_W-1:0] beat,
		output logic [NUM_DIR-1:0] moves);
		logic [POS_W-1:0]   x;
		logic [POS_W-1:0]   y;
		logic [POS_W-1:0]   hat;
		logic [NUM_DIR-1:0] keys;
		logic [NUM_DIR-1:0] held_now;
		logic [NUM_DIR-1:0] held_old;
		logic               hat_now;
		x = beat[IN_X_LSB +: POS_W];
		y = beat[IN_Y_LSB +: POS_W];
		hat = beat[IN_HAT_LSB +: POS_W];
		keys = beat[IN_KEY_LSB +: NUM_DIR];
		moves = keys;
		// failed read in pad mode latches keyboard-only, this frame included
		if (pad_mode && !beat[IN_OK_BIT])
			kbd_latched = 1'b1;
		if (pad_mode && !kbd_latched) begin
			held_now[DIR_UP]    = y < low_thr;
			held_now[DIR_DOWN]  = y > high_thr;
			held_now[DIR_LEFT]  = x < low_thr;
			held_now[DIR_RIGHT] = x > high_thr;
			held_old[DIR_UP]    = prev_y < low_thr;
			held_old[DIR_DOWN]  = prev_y > high_thr;
			held_old[DIR_LEFT]  = prev_x < low_thr;
			held_old[DIR_RIGHT] = prev_x > high_thr;
			for (int d = 0; d < NUM_DIR; d++) begin
				hat_now = (hat == hat_dir_code[d]);
				stick_hold[d] = hold_next(stick_hold[d], held_now[d]);
				hat_hold[d] = hold_next(hat_hold[d], hat_now);
				moves[d] = keys[d] || (hat_now && prev_hat != hat_dir_code[d])
					|| (held_now[d] && !held_old[d])
					|| repeat_due(stick_hold[d]) || repeat_due(hat_hold[d]);
			end
			prev_x = x;
			prev_y = y;
			prev_hat = hat;
		end
	endtask

	// Watch all three channels; results are compared before new frames are queued
	always @(posedge clk or negedge arst_n) begin : watch_beats
		logic [NUM_DIR-1:0] want;
		logic [NUM_DIR-1:0] moves;
		logic               bad;
		if (!arst_n) begin
			pad_mode = 1'b1;
			low_thr = LOW_THR_RST;
			high_thr = HIGH_THR_RST;
			hat_dir_code[DIR_UP] = HAT_UP_RST;
			hat_dir_code[DIR_DOWN] = HAT_DOWN_RST;
			hat_dir_code[DIR_LEFT] = HAT_LEFT_RST;
			hat_dir_code[DIR_RIGHT] = HAT_RIGHT_RST;
			prev_x = '0;
			prev_y = '0;
			prev_hat = '0;
			for (int d = 0; d < NUM_DIR; d++) begin
				stick_hold[d] = 0;
				hat_hold[d] = 0;
			end
			kbd_latched = 1'b0;
			move_q.delete();
			fails = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// result beat
			if (m_axis_tvalid && m_axis_tready) begin
				if (move_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("[%0t] move beat %b with no frame outstanding",
							$time, m_axis_tdata);
				end else begin
					want = move_q.pop_front();
					bad = 1'b0;
					for (int d = 0; d < NUM_DIR; d++)
						if (m_axis_tdata[d] !== want[d])
							bad = 1'b1;
					if (m_axis_tdata[OUT_TDATA_W-1:NUM_DIR] !== '0)
						bad = 1'b1;
					if (bad) begin
						fails++;
						if (fails <= 10)
							$display("[%0t] move mismatch (right,left,down,up): exp %b got %b",
								$time, want, m_axis_tdata);
					end
				end
			end
			// register write
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PAD_MODE:  pad_mode = cfg_data[0];
					CFG_LOW_THR:   low_thr = cfg_data;
					CFG_HIGH_THR:  high_thr = cfg_data;
					CFG_HAT_UP:    hat_dir_code[DIR_UP] = cfg_data;
					CFG_HAT_RIGHT: hat_dir_code[DIR_RIGHT] = cfg_data;
					CFG_HAT_DOWN:  hat_dir_code[DIR_DOWN] = cfg_data;
					CFG_HAT_LEFT:  hat_dir_code[DIR_LEFT] = cfg_data;
					default: ;
				endcase
			end
			// frame beat
			if (s_axis_tvalid && s_axis_tready) begin
				predict_moves(s_axis_tdata, moves);
				move_q.push_back(moves);
			end
			fail_count <= fails;
			pending <= move_q.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import dar_pkg::*;

	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
	localparam logic [POS_W-1:0]     HAT_CENTER   = 16'hffff;
	localparam logic [POS_W-1:0]     STICK_MID    = 16'd32767;

	typedef enum int {ZONE_LOW, ZONE_MID, ZONE_HIGH, ZONE_ANY} zone_t;
	typedef enum int {HAT_ON_CODE, HAT_CENTERED, HAT_NOISE} hat_mode_t;

	logic                      clk;
	logic                      arst_n;
	logic [IN_TDATA_W-1:0]     s_axis_tdata;
	logic                      s_axis_tvalid;
	logic                      s_axis_tready;
	logic [OUT_TDATA_W-1:0]    m_axis_tdata;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;
	int                        fail_count;
	int                        pending;

	// register mirror, used only to aim the stimulus
	logic [POS_W-1:0]              thr_low;
	logic [POS_W-1:0]              thr_high;
	logic [NUM_DIR-1:0][POS_W-1:0] hat_dir_code;

	// current hold segment
	int        seg_left;
	logic      seg_long;
	zone_t     x_zone;
	zone_t     y_zone;
	hat_mode_t hat_pick;
	int        hat_dir;

	int frames_sent;
	int reg_writes;

	direction_auto_repeat u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	dar_move_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(99, 0);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic zone_t pick_zone();
		int r;
		r = $urandom_range(99, 0);
		if (r < 30)
			return ZONE_LOW;
		if (r < 55)
			return ZONE_HIGH;
		if (r < 85)
			return ZONE_MID;
		return ZONE_ANY;
	endfunction

	// stick value in a zone of the current thresholds
	function automatic logic [POS_W-1:0] zone_value(input zone_t z);
		case (z)
			ZONE_LOW:
				return (thr_low == 0) ? '0 : POS_W'($urandom_range(thr_low - 1, 0));
			ZONE_HIGH:
				return (thr_high == HAT_CENTER) ? HAT_CENTER
					: POS_W'($urandom_range(65535, thr_high + 1));
			ZONE_MID:
				return POS_W'($urandom_range(thr_high, thr_low));
			default:
				return POS_W'($urandom_range(65535, 0));
		endcase
	endfunction

	function automatic logic [IN_TDATA_W-1:0] pack_frame(input logic [POS_W-1:0] x,
		input logic [POS_W-1:0] y, input logic [POS_W-1:0] hat,
		input logic [NUM_DIR-1:0] keys, input logic ok);
		logic [IN_TDATA_W-1:0] beat;
		beat = '0;
		beat[IN_X_LSB +: POS_W] = x;
		beat[IN_Y_LSB +: POS_W] = y;
		beat[IN_HAT_LSB +: POS_W] = hat;
		beat[IN_KEY_LSB +: NUM_DIR] = keys;
		beat[IN_OK_BIT] = ok;
		return beat;
	endfunction

	// Present one frame beat after a random gap and hold it until taken
	task automatic send_frame(input logic [IN_TDATA_W-1:0] beat);
		int gap;
		gap = idle_len();
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= beat;
		do @(posedge clk); while (!s_axis_tready);
		frames_sent++;
	endtask

	task automatic send_pad(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
		input logic [POS_W-1:0] hat, input logic [NUM_DIR-1:0] keys);
		send_frame(pack_frame(x, y, hat, keys, 1'b1));
	endtask

	// Stop sending and let every outstanding move beat drain
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_LOW_THR:   thr_low = data;
			CFG_HIGH_THR:  thr_high = data;
			CFG_HAT_UP:    hat_dir_code[DIR_UP] = data;
			CFG_HAT_RIGHT: hat_dir_code[DIR_RIGHT] = data;
			CFG_HAT_DOWN:  hat_dir_code[DIR_DOWN] = data;
			CFG_HAT_LEFT:  hat_dir_code[DIR_LEFT] = data;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic write_hat_codes(input logic [POS_W-1:0] up, input logic [POS_W-1:0] right,
		input logic [POS_W-1:0] down, input logic [POS_W-1:0] left);
		write_reg(CFG_HAT_UP, up);
		write_reg(CFG_HAT_RIGHT, right);
		write_reg(CFG_HAT_DOWN, down);
		write_reg(CFG_HAT_LEFT, left);
	endtask

	// Pick the next run of frames: a stick zone per axis and a hat choice
	task automatic new_segment();
		int r;
		seg_long = ($urandom_range(99, 0) < 15);
		seg_left = seg_long ? $urandom_range(130, 95) : $urandom_range(12, 1);
		x_zone = pick_zone();
		y_zone = pick_zone();
		r = $urandom_range(99, 0);
		hat_pick = (r < 55) ? HAT_ON_CODE : ((r < 85) ? HAT_CENTERED : HAT_NOISE);
		hat_dir = $urandom_range(NUM_DIR - 1, 0);
		// long holds keep x deflected and mostly the hat on a code, to reach repeat
		if (seg_long) begin
			if (x_zone == ZONE_MID || x_zone == ZONE_ANY)
				x_zone = ($urandom_range(1, 0) != 0) ? ZONE_LOW : ZONE_HIGH;
			if ($urandom_range(99, 0) < 70)
				hat_pick = HAT_ON_CODE;
		end
	endtask

	// Hold segments with random content, some noise frames in the short ones
	task automatic run_random(input int count, input int fail_pct);
		logic [POS_W-1:0]   x;
		logic [POS_W-1:0]   y;
		logic [POS_W-1:0]   hat;
		logic [NUM_DIR-1:0] keys;
		logic               ok;
		for (int i = 0; i < count; i++) begin
			if (seg_left == 0)
				new_segment();
			seg_left--;
			x = zone_value(x_zone);
			y = zone_value(y_zone);
			case (hat_pick)
				HAT_ON_CODE:  hat = hat_dir_code[hat_dir];
				HAT_CENTERED: hat = HAT_CENTER;
				default:      hat = POS_W'($urandom_range(65535, 0));
			endcase
			if (!seg_long && $urandom_range(99, 0) < 10) begin
				x = POS_W'($urandom_range(65535, 0));
				y = POS_W'($urandom_range(65535, 0));
				hat = POS_W'($urandom_range(65535, 0));
			end
			for (int d = 0; d < NUM_DIR; d++)
				keys[d] = ($urandom_range(99, 0) < 10);
			ok = ($urandom_range(99, 0) >= fail_pct);
			send_frame(pack_frame(x, y, hat, keys, ok));
		end
	endtask

	// Receiver: bursts of ready broken by random stalls
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			repeat ($urandom_range(40, 1)) begin
				@(negedge clk);
				m_axis_tready <= 1'b1;
			end
			repeat (idle_len()) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
			end
		end
	end

	// Stimulus and verdict
	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PAD_MODE;
		cfg_data = '0;
		thr_low = LOW_THR_RST;
		thr_high = HIGH_THR_RST;
		hat_dir_code[DIR_UP] = HAT_UP_RST;
		hat_dir_code[DIR_DOWN] = HAT_DOWN_RST;
		hat_dir_code[DIR_LEFT] = HAT_LEFT_RST;
		hat_dir_code[DIR_RIGHT] = HAT_RIGHT_RST;
		seg_left = 0;
		frames_sent = 0;
		reg_writes = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: stick extremes and threshold edges, hat codes, key edges
		send_pad(STICK_MID, STICK_MID, HAT_CENTER, 4'b0000);
		send_pad(16'd0, 16'hffff, HAT_CENTER, 4'b0000);
		send_pad(16'd0, 16'hffff, HAT_CENTER, 4'b0000);
		send_pad(16'hffff, 16'd0, HAT_CENTER, 4'b0000);
		send_pad(LOW_THR_RST, HIGH_THR_RST, HAT_CENTER, 4'b0000);
		send_pad(LOW_THR_RST - 1'b1, HIGH_THR_RST + 1'b1, HAT_CENTER, 4'b0000);
		send_pad(HIGH_THR_RST + 1'b1, LOW_THR_RST - 1'b1, HAT_CENTER, 4'b0000);
		send_pad(STICK_MID, STICK_MID, HAT_UP_RST, 4'b0000);
		send_pad(STICK_MID, STICK_MID, HAT_UP_RST, 4'b0000);
		send_pad(STICK_MID, STICK_MID, HAT_RIGHT_RST, 4'b0000);
		send_pad(STICK_MID, STICK_MID, HAT_DOWN_RST, 4'b0000);
		send_pad(STICK_MID, STICK_MID, HAT_LEFT_RST, 4'b0000);
		send_pad(STICK_MID, STICK_MID, HAT_CENTER, 4'b0000);
		send_pad(STICK_MID, STICK_MID, HAT_CENTER, 4'b1111);
		send_pad(STICK_MID, STICK_MID, HAT_CENTER, 4'b0101);
		send_pad(STICK_MID, STICK_MID, HAT_CENTER, 4'b1010);
		send_pad(16'd0, 16'd0, HAT_UP_RST, 4'b1111);
		send_pad(STICK_MID, STICK_MID, HAT_CENTER, 4'b0000);

		// default registers, long holds reach repeat and the counter wrap
		run_random(225, 0);
		wait_idle();
		run_random(225, 0);

		// thresholds at the extremes: no stick deflection at all
		write_reg(CFG_LOW_THR, 16'd0);
		write_reg(CFG_HIGH_THR, 16'hffff);
		write_hat_codes(HAT_CENTER, 16'd0, 16'd1, 16'hfffe);
		run_random(150, 0);

		// inverted thresholds, all hat codes the same
		write_reg(CFG_LOW_THR, 16'hffff);
		write_reg(CFG_HIGH_THR, 16'd0);
		write_hat_codes(16'h1234, 16'h1234, 16'h1234, 16'h1234);
		run_random(150, 0);

		// random registers
		write_reg(CFG_LOW_THR, CFG_DATA_W'($urandom_range(40000, 1000)));
		write_reg(CFG_HIGH_THR, CFG_DATA_W'($urandom_range(60000, 20000)));
		write_hat_codes(POS_W'($urandom_range(65535, 0)), POS_W'($urandom_range(65535, 0)),
			POS_W'($urandom_range(65535, 0)), POS_W'($urandom_range(65535, 0)));
		run_random(150, 0);

		// keyboard only: only bit 0 of the data counts, failed reads do not latch
		write_reg(CFG_PAD_MODE, 16'hfffe);
		write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom_range(65535, 0)));
		run_random(100, 50);

		// back to the pad with default registers; counters resume where they held
		write_reg(CFG_PAD_MODE, 16'h0001);
		write_reg(CFG_LOW_THR, LOW_THR_RST);
		write_reg(CFG_HIGH_THR, HIGH_THR_RST);
		write_hat_codes(HAT_UP_RST, HAT_RIGHT_RST, HAT_DOWN_RST, HAT_LEFT_RST);
		run_random(100, 0);
		wait_idle();
		run_random(100, 0);

		// failed reads latch keyboard-only mode until reset, pad mode writes or not
		run_random(100, 10);
		write_reg(CFG_PAD_MODE, 16'h0000);
		write_reg(CFG_PAD_MODE, 16'h0001);
		run_random(20, 0);

		wait_idle();
		repeat (5) @(posedge clk);
		$display("Sent %0d frames across %0d register writes: default, extreme, inverted,",
			frames_sent, reg_writes);
		$display("random and keyboard-only settings, ending in latched keyboard-only mode.");
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== direction_auto_repeat.f =====
src/dar_pkg.sv
src/direction_auto_repeat.sv
dv/dar_move_checker.sv
dv/tb_top.sv
